### design/llld_pkg.sv
// Shared types and constants for the least-loaded list dispatcher.
// No dependencies; imported by every module of the block.
package llld_pkg;

  localparam int COST_W       = 32;
  localparam int TOTAL_W      = 40;
  localparam int WORKER_W     = 4;
  localparam int COUNT_W      = 5;
  localparam int MAX_WORKERS_DEF = 16;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd4;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              last_unit;
  } unit_t;

  typedef struct packed {
    logic [WORKER_W-1:0] worker;
    logic [TOTAL_W-1:0]  finish_time;
    logic [TOTAL_W-1:0]  makespan;
    logic                run_done;
  } result_t;

  // Handshake between the input queue and the scheduler.
  typedef struct packed {
    logic  valid;
    unit_t unit;
  } queue_head_t;

endpackage

### design/llld_front.sv
// Input side of the dispatcher: a two-word queue that takes work units.
// Depends on llld_pkg.
module llld_front import llld_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        unit_valid,
  output logic        unit_ready,
  input  unit_t       unit,
  output queue_head_t head,
  input  logic        pop
);

  logic [1:0] slots_used;
  logic       wr_ptr;
  logic       rd_ptr;
  unit_t      slot [2];
  logic       push;

  assign unit_ready = (slots_used != 2'd2);
  assign push       = unit_valid && unit_ready;
  assign head.valid = (slots_used != 2'd0);
  assign head.unit  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= 2'd0;
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   slots_used <= slots_used + 2'd1;
        2'b01:   slots_used <= slots_used - 2'd1;
        default: slots_used <= slots_used;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= unit;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) slots_used <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> slots_used != 2'd0)
    else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (slots_used == 2'd0 || slots_used == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

### design/llld_back.sv
// Scheduler: scans busy totals one worker a cycle, picks the least loaded,
// updates its total and presents the result word. Depends on llld_pkg.
module llld_back import llld_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] worker_count,
  input  queue_head_t        head,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result
);

  localparam int IW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int NW   = $clog2(MAX_WORKERS + 1);
  localparam int CMPW = (NW > COUNT_W) ? NW : COUNT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]             state;
  logic [IW-1:0]          issue_idx;
  logic                   issue_done;
  logic [IW-1:0]          n_last;
  logic [IW-1:0]          n_last_next;
  logic                   rd_live;
  logic [IW-1:0]          rd_idx;
  logic [TOTAL_W-1:0]     rd_data;
  logic                   rd_ok;
  logic [TOTAL_W-1:0]     min_val;
  logic [IW-1:0]          pick;
  logic [COST_W-1:0]      cur_cost;
  logic                   cur_last;
  logic [TOTAL_W-1:0]     largest;
  logic [MAX_WORKERS-1:0] entry_ok;
  logic [TOTAL_W-1:0]     mem [MAX_WORKERS];

  logic [CMPW-1:0]        count_ext;
  logic [CMPW-1:0]        n_act;
  logic [TOTAL_W-1:0]     eff;
  logic [TOTAL_W:0]       sum;
  logic [TOTAL_W-1:0]     total;
  logic [TOTAL_W-1:0]     largest_next;
  logic                   out_free;
  logic                   commit;

  // Clamp the configured count to 1..MAX_WORKERS.
  always_comb begin
    count_ext = CMPW'(worker_count);
    if (count_ext == '0) begin
      n_act = CMPW'(1);
    end else if (count_ext > CMPW'(MAX_WORKERS)) begin
      n_act = CMPW'(MAX_WORKERS);
    end else begin
      n_act = count_ext;
    end
    n_last_next = IW'(n_act - CMPW'(1));
  end

  assign eff          = rd_ok ? rd_data : '0;
  assign sum          = (TOTAL_W+1)'(min_val) + (TOTAL_W+1)'(cur_cost);
  assign total        = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
  assign largest_next = (total > largest) ? total : largest;
  assign out_free     = !result_valid || result_ready;
  assign commit       = (state == S_FINISH) && out_free;
  assign pop          = (state == S_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      issue_idx    <= '0;
      issue_done   <= 1'b0;
      rd_live      <= 1'b0;
      entry_ok     <= '0;
      largest      <= '0;
      result_valid <= 1'b0;
    end else begin
      rd_live <= (state == S_SCAN) && !issue_done;
      if (result_valid && result_ready && !commit) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            state      <= S_SCAN;
            issue_idx  <= '0;
            issue_done <= 1'b0;
          end
        end
        S_SCAN: begin
          if (!issue_done) begin
            if (issue_idx == n_last) begin
              issue_done <= 1'b1;
            end else begin
              issue_idx <= issue_idx + IW'(1);
            end
          end
          if (rd_live && rd_idx == n_last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
            if (cur_last) begin
              entry_ok <= '0;
              largest  <= '0;
            end else begin
              entry_ok[pick] <= 1'b1;
              largest        <= largest_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: item capture, running minimum, result word.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_cost <= head.unit.cost;
      cur_last <= head.unit.last_unit;
      n_last   <= n_last_next;
    end
    rd_idx <= issue_idx;
    if (rd_live && (rd_idx == '0 || eff < min_val)) begin
      min_val <= eff;
      pick    <= rd_idx;
    end
    if (commit) begin
      result.worker      <= WORKER_W'(pick);
      result.finish_time <= total;
      result.makespan    <= cur_last ? largest_next : '0;
      result.run_done    <= cur_last;
    end
  end

  // Busy-total memory: one read port for the scan, one write port.
  always_ff @(posedge clk) begin
    if (commit) begin
      mem[pick] <= total;
    end
    rd_data <= mem[issue_idx];
    rd_ok   <= entry_ok[issue_idx];
  end

  a_pick_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |-> pick <= n_last)
    else $error("picked worker beyond active count");
  a_read_range: assert property (@(posedge clk) disable iff (rst)
    rd_live |-> rd_idx <= n_last)
    else $error("scan read beyond active count");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !pop)
    else $error("queue popped while scheduler busy");
  a_commit_clear: assert property (@(posedge clk) disable iff (rst)
    (commit && cur_last) |=> (entry_ok == '0 && largest == '0))
    else $error("totals not cleared after last unit");

endmodule

### design/least_loaded_list_dispatcher_top.sv
// Top level of the least-loaded list dispatcher: config register, input
// queue and scheduler. Depends on llld_pkg, llld_front, llld_back.
//
// Usage:
//   unit channel (unit_valid/unit_ready/unit) takes one work word: a cost in
//   ticks and a last_unit flag. result channel (result_valid/result_ready/
//   result) returns one word per unit: the chosen worker, its new busy total
//   (saturating at 2^40-1), and on the last unit of a run the makespan with
//   run_done set; all totals then clear for the next run.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes worker_count; it is
//   always ready. Write it only while no unit is in flight.
// Flow:
//   A unit word reaches the queue head and is popped, the scan reads one
//   busy total per active worker, the last read enters the running minimum,
//   and the chosen total is added, saturated and written back with the result
//   word. A new unit is popped only after the previous result is committed.
// Reset (rst, synchronous): worker_count returns to 4, all totals read as
//   zero at once through per-worker valid bits, queue and result empty.
// Stall: a result holds in the output register while result_ready is low;
//   the scan of the next unit proceeds and the queue keeps taking two words.
module least_loaded_list_dispatcher_top import llld_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               unit_valid,
  output logic               unit_ready,
  input  unit_t              unit,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result
);

  logic [COUNT_W-1:0] worker_count;
  queue_head_t        head;
  logic               pop;

  // Config register: take every write immediately.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= COUNT_RESET;
    end else if (cfg_valid) begin
      worker_count <= cfg_data;
    end
  end

  // Front: accept and queue work words.
  llld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_ready (unit_ready),
    .unit       (unit),
    .head       (head),
    .pop        (pop)
  );

  // Back: scan totals, dispatch, present the result word.
  llld_back #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .worker_count (worker_count),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
